### hw/rtl/awst_pkg.sv
// Shared types and codes for the aging wait slot table.
package awst_pkg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SIGNAL = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_EVICTED   = 3'd4,
        ST_NONE      = 3'd5
    } t_status;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned TAG_W  = 32;
    localparam int unsigned AGE_W  = 8;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned USED_W = 7;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } t_entry;

    typedef struct packed {
        t_status           status;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
        logic [USED_W-1:0] used;
    } t_result;

    // Write side of the entry memory.
    typedef struct packed {
        logic   en;
        t_entry data;
    } t_wr_ctl;

endpackage

### hw/rtl/aging_wait_slot_table.sv
// Top level: ordered, compacting table of aging entries with a scan sequencer.
// Add writes its entry and moves to the emit state; remove, signal and tick scan from the
// first entry scanned to the end, one entry per cycle (a held eviction can stall the scan)
// through the single port pair of the entry memory. One word is worked on at a time;
// output stalls hold the final result in the emit state and, mid-scan, a second eviction.
// Reset clears occupancy and sets the age limit to 3; the memory is not cleared.
module aging_wait_slot_table #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_entry_key,
    input  logic [31:0] i_entry_tag,
    input  logic [5:0]  i_slot_position,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_result_key,
    output logic [31:0] o_result_tag,
    output logic [6:0]  o_entries_used,
    output logic        o_last_result
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned XW = (CW > awst_pkg::POS_W) ? CW : awst_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                           r_state, n_state;
    logic [CW-1:0]                    r_count, n_count;
    logic [CW-1:0]                    r_end, n_end;
    logic [CW-1:0]                    r_rd, n_rd;
    logic [CW-1:0]                    r_wr, n_wr;
    logic                             r_found, n_found;
    awst_pkg::t_action                r_action, n_action;
    logic [awst_pkg::KEY_W-1:0]       r_key, n_key;
    logic [awst_pkg::TAG_W-1:0]       r_tag, n_tag;
    logic [awst_pkg::POS_W-1:0]       r_pos, n_pos;
    awst_pkg::t_result                r_res, n_res;
    logic [awst_pkg::AGE_W-1:0]       r_age_limit;
    logic                             r_out_valid;
    awst_pkg::t_result                r_out;
    logic                             r_out_last;

    awst_pkg::t_wr_ctl                mem_wr;
    logic [AW-1:0]                    mem_wr_addr;
    logic                             mem_rd_en;
    logic [AW-1:0]                    mem_rd_addr;
    awst_pkg::t_entry                 mem_rd_data;

    logic                             out_free;
    logic                             out_load;
    awst_pkg::t_result                out_data;
    logic                             out_last;
    logic                             skip;
    logic                             blocked;

    awst_mem #(
        .DEPTH(TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_wr_addr (mem_wr_addr),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // Decide whether the word under the scan pointer leaves the table.
    always_comb begin
        case (r_action)
            awst_pkg::ACT_REMOVE: skip = !r_found && (mem_rd_data.key == r_key);
            awst_pkg::ACT_SIGNAL: skip = !r_found;
            awst_pkg::ACT_TICK:   skip = (mem_rd_data.age == r_age_limit);
            default:              skip = 1'b0;
        endcase
    end

    // A new eviction must first push out the one held back, whose last flag
    // is only known once the next eviction or the end of the scan is seen.
    assign blocked = (r_action == awst_pkg::ACT_TICK) && skip && r_found && !out_free;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_end       = r_end;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_found     = r_found;
        n_action    = r_action;
        n_key       = r_key;
        n_tag       = r_tag;
        n_pos       = r_pos;
        n_res       = r_res;
        mem_wr      = '0;
        mem_wr_addr = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        out_load    = 1'b0;
        out_data    = r_res;
        out_last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = awst_pkg::t_action'(i_action);
                    n_key    = i_entry_key;
                    n_tag    = i_entry_tag;
                    n_pos    = i_slot_position;
                    n_end    = r_count;
                    n_found  = 1'b0;
                    n_state  = S_START;
                end
            end

            S_START: begin
                n_rd  = '0;
                n_wr  = '0;
                n_res = '{status: awst_pkg::ST_NONE, key: '0, tag: '0,
                          used: awst_pkg::USED_W'(r_count)};
                case (r_action)
                    awst_pkg::ACT_ADD: begin
                        n_state = S_EMIT;
                        if (r_count == CW'(TABLE_DEPTH)) begin
                            n_res.status = awst_pkg::ST_FULL;
                        end else begin
                            mem_wr.en       = 1'b1;
                            mem_wr.data.key = r_key;
                            mem_wr.data.tag = r_tag;
                            mem_wr.data.age = '0;
                            mem_wr_addr     = r_count[AW-1:0];
                            n_count         = r_count + CW'(1);
                            n_res.status    = awst_pkg::ST_OK;
                            n_res.used      = awst_pkg::USED_W'(r_count + CW'(1));
                        end
                    end
                    awst_pkg::ACT_REMOVE: begin
                        n_res.status = awst_pkg::ST_NOT_FOUND;
                    end
                    awst_pkg::ACT_SIGNAL: begin
                        n_res.status = awst_pkg::ST_BAD_POS;
                        n_rd         = CW'(r_pos);
                        n_wr         = CW'(r_pos);
                    end
                    default: begin
                        n_res.status = awst_pkg::ST_NONE;
                    end
                endcase
                if (r_action != awst_pkg::ACT_ADD) begin
                    if ((r_action == awst_pkg::ACT_SIGNAL) ?
                            (XW'(r_pos) >= XW'(r_count)) : (r_count == '0)) begin
                        n_state = S_EMIT;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = n_rd[AW-1:0];
                        n_state     = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (!blocked) begin
                    if (skip) begin
                        n_found = 1'b1;
                        n_count = r_count - CW'(1);
                        n_res.used = awst_pkg::USED_W'(r_count - CW'(1));
                        n_res.tag  = mem_rd_data.tag;
                        case (r_action)
                            awst_pkg::ACT_TICK: begin
                                n_res.status = awst_pkg::ST_EVICTED;
                                n_res.key    = mem_rd_data.key;
                                out_load     = r_found;
                                out_last     = 1'b0;
                            end
                            awst_pkg::ACT_REMOVE: begin
                                n_res.status = awst_pkg::ST_OK;
                                n_res.key    = mem_rd_data.key;
                            end
                            default: begin
                                n_res.status = awst_pkg::ST_OK;
                                n_res.key    = '0;
                            end
                        endcase
                    end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.data = mem_rd_data;
                        if (r_action == awst_pkg::ACT_TICK) begin
                            mem_wr.data.age = mem_rd_data.age + awst_pkg::AGE_W'(1);
                        end
                        mem_wr_addr = r_wr[AW-1:0];
                        n_wr        = r_wr + CW'(1);
                    end
                    n_rd = r_rd + CW'(1);
                    if (n_rd < r_end) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = n_rd[AW-1:0];
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_age_limit <= 8'd3;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
            if (i_cfg_wr_en) begin
                r_age_limit <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_end    <= n_end;
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_action <= n_action;
        r_key    <= n_key;
        r_tag    <= n_tag;
        r_pos    <= n_pos;
        r_res    <= n_res;
        if (out_load) begin
            r_out      <= out_data;
            r_out_last <= out_last;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_result_key   = r_out.key;
    assign o_result_tag   = r_out.tag;
    assign o_entries_used = r_out.used;
    assign o_last_result  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("occupancy above table depth");

    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_wr <= r_rd))
        else $error("compaction write pointer ahead of read pointer");

    a_not_last_is_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_result) |-> (o_status == awst_pkg::ST_EVICTED))
        else $error("non-final result that is not an eviction");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_START))
        else $error("accepted word did not start the sequencer");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd < r_end))
        else $error("scan pointer beyond the entries present at start");
`endif

endmodule

### hw/rtl/awst_mem.sv
// Entry memory: one write port and one read port with registered read data.
module awst_mem #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                      i_clk,
    input  awst_pkg::t_wr_ctl         i_wr,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  logic                      i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output awst_pkg::t_entry          o_rd_data
);

    awst_pkg::t_entry r_mem [DEPTH];
    awst_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
    end

    // Read data holds while no read is issued, so a stalled scan keeps its word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### verif/aging_wait_slot_table_checker.sv
// Checker for the aging wait slot table: predicts every result word and compares it.
`timescale 1ns / 100ps

module aging_wait_slot_table_checker #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_entry_key,
    input  logic [31:0] i_entry_tag,
    input  logic [5:0]  i_slot_position,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_result_key,
    input  logic [31:0] i_result_tag,
    input  logic [6:0]  i_entries_used,
    input  logic        i_last_result,
    output logic [31:0] o_fail_count,
    output logic [31:0] o_pending_count
);

    typedef struct packed {
        awst_pkg::t_status           status;
        logic [awst_pkg::KEY_W-1:0]  key;
        logic [awst_pkg::TAG_W-1:0]  tag;
        logic [awst_pkg::USED_W-1:0] used;
        logic                        last;
    } t_table_result;

    // Shadow copy of the table contents, kept in arrival order.
    logic [awst_pkg::KEY_W-1:0] key_mem [0:TABLE_DEPTH-1];
    logic [awst_pkg::TAG_W-1:0] tag_mem [0:TABLE_DEPTH-1];
    logic [awst_pkg::AGE_W-1:0] age_mem [0:TABLE_DEPTH-1];
    int                         fill;
    logic [7:0]                 age_limit;

    t_table_result    predicted_results [$];
    t_table_result    want;
    int               fail_total = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_total++;
    endtask

    function automatic t_table_result make_result(input awst_pkg::t_status st,
                                                  input logic [31:0] key,
                                                  input logic [31:0] tag,
                                                  input logic last);
        t_table_result w;
        w.status = st;
        w.key    = key;
        w.tag    = tag;
        w.used   = fill[awst_pkg::USED_W-1:0];
        w.last   = last;
        return w;
    endfunction

    // Drop one entry and shift the rest down so the order is kept.
    task automatic close_slot(input int at);
        for (int j = at; j + 1 < fill; j++) begin
            key_mem[j] = key_mem[j+1];
            tag_mem[j] = tag_mem[j+1];
            age_mem[j] = age_mem[j+1];
        end
        fill--;
    endtask

    task automatic apply_table_op(input awst_pkg::t_action act, input logic [31:0] key,
                                  input logic [31:0] tag, input logic [5:0] pos);
        int            idx;
        bit            found;
        bit            have_held;
        logic [31:0]   hit_key;
        logic [31:0]   hit_tag;
        t_table_result held;
        found = 1'b0;
        have_held = 1'b0;
        idx = 0;
        case (act)
            awst_pkg::ACT_ADD: begin
                if (fill >= TABLE_DEPTH) begin
                    predicted_results.push_back(
                        make_result(awst_pkg::ST_FULL, '0, '0, 1'b1));
                end else begin
                    key_mem[fill] = key;
                    tag_mem[fill] = tag;
                    age_mem[fill] = '0;
                    fill++;
                    predicted_results.push_back(
                        make_result(awst_pkg::ST_OK, '0, '0, 1'b1));
                end
            end
            awst_pkg::ACT_REMOVE: begin
                while (!found && idx < fill) begin
                    if (key_mem[idx] == key) begin
                        found = 1'b1;
                    end else begin
                        idx++;
                    end
                end
                if (found) begin
                    hit_tag = tag_mem[idx];
                    close_slot(idx);
                    predicted_results.push_back(
                        make_result(awst_pkg::ST_OK, key, hit_tag, 1'b1));
                end else begin
                    predicted_results.push_back(
                        make_result(awst_pkg::ST_NOT_FOUND, '0, '0, 1'b1));
                end
            end
            awst_pkg::ACT_SIGNAL: begin
                if (int'(pos) >= fill) begin
                    predicted_results.push_back(
                        make_result(awst_pkg::ST_BAD_POS, '0, '0, 1'b1));
                end else begin
                    hit_tag = tag_mem[pos];
                    close_slot(int'(pos));
                    predicted_results.push_back(
                        make_result(awst_pkg::ST_OK, '0, hit_tag, 1'b1));
                end
            end
            default: begin
                // Each eviction word is held back one step so the final one can carry last.
                while (idx < fill) begin
                    if (age_mem[idx] == age_limit) begin
                        hit_key = key_mem[idx];
                        hit_tag = tag_mem[idx];
                        close_slot(idx);
                        if (have_held) begin
                            predicted_results.push_back(held);
                        end
                        held = make_result(awst_pkg::ST_EVICTED, hit_key, hit_tag, 1'b0);
                        have_held = 1'b1;
                    end else begin
                        age_mem[idx] = age_mem[idx] + 1'b1;
                        idx++;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    predicted_results.push_back(held);
                end else begin
                    predicted_results.push_back(
                        make_result(awst_pkg::ST_NONE, '0, '0, 1'b1));
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill = 0;
            age_limit = 8'd3;
            predicted_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected word st=%0d key=%h tag=%h used=%0d",
                                              i_status, i_result_key, i_result_tag,
                                              i_entries_used));
                end else begin
                    want = predicted_results.pop_front();
                    if (i_status !== want.status || i_result_key !== want.key ||
                        i_result_tag !== want.tag || i_entries_used !== want.used ||
                        i_last_result !== want.last) begin
                        report_mismatch($sformatf(
                            "st/key/tag/used/last got %0d/%h/%h/%0d/%b want %0d/%h/%h/%0d/%b",
                            i_status, i_result_key, i_result_tag, i_entries_used,
                            i_last_result, want.status, want.key, want.tag, want.used,
                            want.last));
                    end
                end
            end
            if (i_cfg_wr_en) begin
                age_limit = i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall) begin
                apply_table_op(awst_pkg::t_action'(i_action), i_entry_key, i_entry_tag,
                               i_slot_position);
            end
        end
        o_pending_count <= predicted_results.size();
        o_fail_count <= fail_total;
    end

endmodule

### verif/aging_wait_slot_table_tb.sv
// Testbench top for the aging wait slot table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module aging_wait_slot_table_tb;

    localparam int unsigned TABLE_DEPTH    = 64;
    localparam int unsigned SETTLE_CYCLES  = TABLE_DEPTH + 16;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action = awst_pkg::ACT_ADD;
    logic [31:0] i_entry_key = '0;
    logic [31:0] i_entry_tag = '0;
    logic [5:0]  i_slot_position = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_result_key;
    logic [31:0] o_result_tag;
    logic [6:0]  o_entries_used;
    logic        o_last_result;

    logic [31:0] fail_count;
    logic [31:0] pending_count;

    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 54;
    int unsigned idle_cycles = 0;
    logic [31:0] key_pool [0:7];

    aging_wait_slot_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_entry_key    (i_entry_key),
        .i_entry_tag    (i_entry_tag),
        .i_slot_position(i_slot_position),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_key   (o_result_key),
        .o_result_tag   (o_result_tag),
        .o_entries_used (o_entries_used),
        .o_last_result  (o_last_result)
    );

    aging_wait_slot_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_entry_key    (i_entry_key),
        .i_entry_tag    (i_entry_tag),
        .i_slot_position(i_slot_position),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_result_key   (o_result_key),
        .i_result_tag   (o_result_tag),
        .i_entries_used (o_entries_used),
        .i_last_result  (o_last_result),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Ends the run if neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("aging_wait_slot_table verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 80) begin
            return key_pool[$urandom_range(7)];
        end
        return $urandom;
    endfunction

    task automatic send_word(input awst_pkg::t_action act, input logic [31:0] key,
                             input logic [31:0] tag, input logic [5:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_entry_key     <= key;
        i_entry_tag     <= tag;
        i_slot_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Holds the sender until every predicted word has come back, then lets the block settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_age_limit(input logic [7:0] limit);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= limit;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_word();
        int unsigned pick;
        logic [5:0]  pos;
        pick = $urandom_range(99);
        pos = ($urandom_range(99) < 75) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
        if (pick < 40) begin
            send_word(awst_pkg::ACT_ADD, pick_key(), $urandom, pos);
        end else if (pick < 60) begin
            send_word(awst_pkg::ACT_REMOVE, pick_key(), $urandom, pos);
        end else if (pick < 75) begin
            send_word(awst_pkg::ACT_SIGNAL, $urandom, $urandom, pos);
        end else begin
            send_word(awst_pkg::ACT_TICK, $urandom, $urandom, pos);
        end
    endtask

    initial begin
        for (int k = 0; k < 8; k++) begin
            key_pool[k] = $urandom;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tick, extremes, duplicate keys, misses and bad positions.
        send_word(awst_pkg::ACT_TICK, '0, '0, '0);
        send_word(awst_pkg::ACT_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
        send_word(awst_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 6'd63);
        send_word(awst_pkg::ACT_ADD, 32'h1234_5678, 32'h0BAD_F00D, 6'd0);
        send_word(awst_pkg::ACT_ADD, 32'h1234_5678, 32'hC0DE_0002, 6'd0);
        send_word(awst_pkg::ACT_REMOVE, 32'hFFFF_FFFF, '0, 6'd0);
        send_word(awst_pkg::ACT_REMOVE, 32'h1234_5678, '0, 6'd0);
        send_word(awst_pkg::ACT_REMOVE, 32'h0000_BEEF, '0, 6'd0);
        send_word(awst_pkg::ACT_SIGNAL, '0, '0, 6'd63);
        send_word(awst_pkg::ACT_SIGNAL, '0, '0, 6'd1);
        send_word(awst_pkg::ACT_SIGNAL, '0, '0, 6'd0);
        send_word(awst_pkg::ACT_SIGNAL, '0, '0, 6'd0);
        send_word(awst_pkg::ACT_ADD, 32'hAAAA_AAAA, 32'h5555_5555, 6'd0);
        send_word(awst_pkg::ACT_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 6'd0);
        send_word(awst_pkg::ACT_ADD, 32'h8000_0001, 32'h7FFF_FFFE, 6'd0);
        // The fourth tick at the reset limit evicts all three entries.
        repeat (4) send_word(awst_pkg::ACT_TICK, '0, '0, '0);

        // An entry already older than a lowered limit stays until its age wraps.
        set_age_limit(8'd6);
        send_word(awst_pkg::ACT_ADD, 32'h0000_0A0A, 32'h0000_0B0B, 6'd0);
        repeat (4) send_word(awst_pkg::ACT_TICK, '0, '0, '0);
        set_age_limit(8'd1);
        send_word(awst_pkg::ACT_ADD, 32'h0000_0C0C, 32'h0000_0D0D, 6'd0);
        repeat (2) send_word(awst_pkg::ACT_TICK, '0, '0, '0);

        // Fill the table past full, then evict almost everything in one sweep.
        set_age_limit(8'd255);
        repeat (67) send_word(awst_pkg::ACT_ADD, pick_key(), $urandom, 6'($urandom_range(63)));
        set_age_limit(8'd0);
        send_word(awst_pkg::ACT_TICK, $urandom, $urandom, 6'($urandom_range(63)));
        repeat (6) send_random_word();

        send_idle_pct = 54;
        recv_idle_pct = 12;
        set_age_limit(8'($urandom_range(2, 6)));
        repeat (8) send_random_word();
        wait_drained();
        repeat (9) send_random_word();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_age_limit(8'd1);
        repeat (12) send_random_word();

        wait_drained();
        if (fail_count == 0) begin
            $display("aging_wait_slot_table verification clean");
        end else begin
            $display("aging_wait_slot_table verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/awst_pkg.sv
hw/rtl/awst_mem.sv
hw/rtl/aging_wait_slot_table.sv
verif/aging_wait_slot_table_checker.sv
verif/aging_wait_slot_table_tb.sv
